[rtl/spi_master_shift_engine_top_defines.svh]
// assertion macros for the spi master shift engine top level
`ifndef SPI_MASTER_SHIFT_ENGINE_TOP_DEFINES_SVH
`define SPI_MASTER_SHIFT_ENGINE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// clocked check, masked while reset is asserted
`define SMSE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds across reset
`define SMSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SMSE_ASSERT(lbl, clk, rst_n, prop, msg)
`define SMSE_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[rtl/spi_mse_pkg.sv]
// shared types and constants for the spi master shift engine
`timescale 1ns / 1ps

package spi_mse_pkg;

    localparam int BYTE_W = 8;
    localparam int MODE_W = 2;
    localparam int HALF_W = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    // request operation codes
    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_START    = 2'd1,
        OP_SELECT   = 2'd2,
        OP_DESELECT = 2'd3
    } op_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPI_MODE   = 2'd0,
        CFG_MSB_FIRST  = 2'd1,
        CFG_HALF_TICKS = 2'd2,
        CFG_CS_ENABLED = 2'd3
    } cfg_idx_t;

    // one result as seen after a request
    typedef struct packed {
        logic              sck_level;
        logic              mosi_level;
        logic              cs_level;
        logic              busy_res;
        logic              rx_valid;
        logic [BYTE_W-1:0] rx_byte;
    } res_t;

endpackage

[rtl/spi_mse_core.sv]
// spi master state: config registers, bit timing and shift registers
`timescale 1ns / 1ps

module spi_mse_core #(
    parameter int FRAME_BITS  = 8,
    parameter int DELAY_WIDTH = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 step,
    input  spi_mse_pkg::op_t                     op,
    input  logic [spi_mse_pkg::BYTE_W-1:0]       tx_byte,
    input  logic                                 miso_level,
    input  logic                                 cfg_wr_en,
    input  logic [spi_mse_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spi_mse_pkg::CFG_DATA_W-1:0]   cfg_data,
    output spi_mse_pkg::res_t                    res
);

    localparam int BitW  = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
    localparam int ByteW = spi_mse_pkg::BYTE_W;
    localparam logic [BitW-1:0] LastBit = BitW'(FRAME_BITS - 1);

    // configuration registers
    logic [spi_mse_pkg::MODE_W-1:0] spi_mode_reg;
    logic                           msb_first_reg;
    logic [spi_mse_pkg::HALF_W-1:0] half_ticks_reg;
    logic                           cs_enabled_reg;

    // transfer state
    logic [BitW-1:0]        bit_index_reg, bit_index_next;
    logic                   half_phase_reg, half_phase_next;
    logic [DELAY_WIDTH-1:0] delay_count_reg, delay_count_next;
    logic [FRAME_BITS-1:0]  tx_shift_reg, tx_shift_next;
    logic [FRAME_BITS-1:0]  rx_shift_reg, rx_shift_next;
    logic                   clock_out_reg, clock_out_next;
    logic                   data_out_reg, data_out_next;
    logic                   select_out_reg, select_out_next;
    logic                   active_reg, active_next;

    logic                   cpol, cpha;
    logic [DELAY_WIDTH-1:0] delay_limit;
    logic [BitW-1:0]        bit_inc;
    logic [BitW-1:0]        pos_cur, pos_inc, pos_first;
    logic [FRAME_BITS-1:0]  tx_load;
    logic                   done;

    assign cpol        = spi_mode_reg[1];
    assign cpha        = spi_mode_reg[0];
    assign delay_limit = DELAY_WIDTH'(half_ticks_reg);
    assign bit_inc     = BitW'(bit_index_reg + 1'b1);
    assign tx_load     = FRAME_BITS'(tx_byte);

    // bit positions for the current bit, the following bit and the first bit
    assign pos_cur   = msb_first_reg ? (LastBit - bit_index_reg) : bit_index_reg;
    assign pos_inc   = msb_first_reg ? (LastBit - bit_inc) : bit_inc;
    assign pos_first = msb_first_reg ? LastBit : '0;

    // next state for one request
    always_comb begin
        bit_index_next   = bit_index_reg;
        half_phase_next  = half_phase_reg;
        delay_count_next = delay_count_reg;
        tx_shift_next    = tx_shift_reg;
        rx_shift_next    = rx_shift_reg;
        clock_out_next   = clock_out_reg;
        data_out_next    = data_out_reg;
        select_out_next  = select_out_reg;
        active_next      = active_reg;
        done             = 1'b0;
        if (active_reg) begin
            if (delay_count_reg < delay_limit) begin
                delay_count_next = delay_count_reg + 1'b1;
            end else begin
                delay_count_next = '0;
                if (!half_phase_reg) begin
                    // leading edge
                    clock_out_next        = cpha ? cpol : ~cpol;
                    rx_shift_next[pos_cur] = rx_shift_reg[pos_cur] | miso_level;
                    half_phase_next       = 1'b1;
                end else if (bit_index_reg == LastBit) begin
                    // last trailing edge ends the frame
                    active_next     = 1'b0;
                    clock_out_next  = cpol;
                    half_phase_next = 1'b0;
                    done            = 1'b1;
                end else begin
                    // trailing edge, launch the following bit
                    bit_index_next  = bit_inc;
                    clock_out_next  = cpha ? ~cpol : cpol;
                    data_out_next   = tx_shift_reg[pos_inc];
                    half_phase_next = 1'b0;
                end
            end
        end else begin
            case (op)
                spi_mse_pkg::OP_START: begin
                    tx_shift_next    = tx_load;
                    rx_shift_next    = '0;
                    bit_index_next   = '0;
                    active_next      = 1'b1;
                    clock_out_next   = cpha ? ~cpol : cpol;
                    data_out_next    = tx_load[pos_first];
                    half_phase_next  = 1'b0;
                    delay_count_next = '0;
                end
                spi_mse_pkg::OP_SELECT: begin
                    if (cs_enabled_reg) begin
                        select_out_next = 1'b0;
                    end
                end
                spi_mse_pkg::OP_DESELECT: begin
                    if (cs_enabled_reg) begin
                        select_out_next = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result fields follow the state after the request
    always_comb begin
        res.sck_level  = clock_out_next;
        res.mosi_level = data_out_next;
        res.cs_level   = cs_enabled_reg ? select_out_next : 1'b1;
        res.busy_res   = active_next;
        res.rx_valid   = done;
        res.rx_byte    = done ? ByteW'(rx_shift_reg) : '0;
    end

    // config and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spi_mode_reg    <= '0;
            msb_first_reg   <= 1'b1;
            half_ticks_reg  <= '0;
            cs_enabled_reg  <= 1'b1;
            bit_index_reg   <= '0;
            half_phase_reg  <= 1'b0;
            delay_count_reg <= '0;
            tx_shift_reg    <= '0;
            rx_shift_reg    <= '0;
            clock_out_reg   <= 1'b0;
            data_out_reg    <= 1'b0;
            select_out_reg  <= 1'b1;
            active_reg      <= 1'b0;
        end else begin
            if (step) begin
                bit_index_reg   <= bit_index_next;
                half_phase_reg  <= half_phase_next;
                delay_count_reg <= delay_count_next;
                tx_shift_reg    <= tx_shift_next;
                rx_shift_reg    <= rx_shift_next;
                clock_out_reg   <= clock_out_next;
                data_out_reg    <= data_out_next;
                select_out_reg  <= select_out_next;
                active_reg      <= active_next;
            end
            if (cfg_wr_en) begin
                case (spi_mse_pkg::cfg_idx_t'(cfg_index))
                    spi_mse_pkg::CFG_SPI_MODE: begin
                        spi_mode_reg <= cfg_data[spi_mse_pkg::MODE_W-1:0];
                        // idle clock follows the polarity at once
                        if (!active_reg) begin
                            clock_out_reg <= cfg_data[1];
                        end
                    end
                    spi_mse_pkg::CFG_MSB_FIRST:  msb_first_reg  <= cfg_data[0];
                    spi_mse_pkg::CFG_HALF_TICKS: half_ticks_reg <= cfg_data[spi_mse_pkg::HALF_W-1:0];
                    spi_mse_pkg::CFG_CS_ENABLED: cs_enabled_reg <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

[rtl/spi_master_shift_engine_top.sv]
// top level of the spi master shift engine with a two-entry result buffer
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------------------
//  s_       | in        | s_valid / s_ready  | s_operation, s_tx_byte, s_miso_level
//  m_       | out       | m_valid / m_ready  | m_sck_level, m_mosi_level, m_cs_level,
//           |           |                    | m_busy_res, m_rx_valid, m_rx_byte
//  cfg_     | in        | cfg_wr_en          | cfg_index, cfg_data
//
//  one request is taken every cycle while s_ready is high; its result is registered
//  the state update in the core is one short combinational pass between registers
//  a second buffer entry keeps s_ready high for one stalled result, so s_ready is
//  low only while both entries hold results
//  reset is synchronous and active low; there is no clearing pass
`timescale 1ns / 1ps
`include "spi_master_shift_engine_top_defines.svh"

module spi_master_shift_engine_top #(
    parameter int FRAME_BITS  = 8,
    parameter int DELAY_WIDTH = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_operation,
    input  logic [spi_mse_pkg::BYTE_W-1:0]       s_tx_byte,
    input  logic                                 s_miso_level,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_sck_level,
    output logic                                 m_mosi_level,
    output logic                                 m_cs_level,
    output logic                                 m_busy_res,
    output logic                                 m_rx_valid,
    output logic [spi_mse_pkg::BYTE_W-1:0]       m_rx_byte,
    input  logic                                 cfg_wr_en,
    input  logic [spi_mse_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spi_mse_pkg::CFG_DATA_W-1:0]   cfg_data
);

    spi_mse_pkg::res_t core_res;
    spi_mse_pkg::res_t m_res_reg;
    spi_mse_pkg::res_t skid_res_reg;
    logic              m_valid_reg;
    logic              skid_valid_reg;
    logic              s_accept;
    logic              m_pop;

    assign s_ready  = !skid_valid_reg;
    assign s_accept = s_valid && s_ready;
    assign m_pop    = m_valid_reg && m_ready;

    spi_mse_core #(
        .FRAME_BITS  (FRAME_BITS),
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (s_accept),
        .op         (spi_mse_pkg::op_t'(s_operation)),
        .tx_byte    (s_tx_byte),
        .miso_level (s_miso_level),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .res        (core_res)
    );

    // result register plus skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_pop) begin
                m_res_reg      <= skid_res_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (s_accept) begin
            if (!m_valid_reg || m_pop) begin
                m_res_reg   <= core_res;
                m_valid_reg <= 1'b1;
            end else begin
                skid_res_reg   <= core_res;
                skid_valid_reg <= 1'b1;
            end
        end else if (m_pop) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sck_level  = m_res_reg.sck_level;
    assign m_mosi_level = m_res_reg.mosi_level;
    assign m_cs_level   = m_res_reg.cs_level;
    assign m_busy_res   = m_res_reg.busy_res;
    assign m_rx_valid   = m_res_reg.rx_valid;
    assign m_rx_byte    = m_res_reg.rx_byte;

    // buffer ordering, frame completion and reset checks
    `SMSE_ASSERT(a_skid_behind_out, aclk, aresetn, skid_valid_reg |-> m_valid_reg, "skid entry without head result")
    `SMSE_ASSERT(a_stall_fills_skid, aclk, aresetn, (s_accept && m_valid_reg && !m_ready) |=> skid_valid_reg, "stalled request not buffered")
    `SMSE_ASSERT(a_done_not_busy, aclk, aresetn, (m_valid_reg && m_res_reg.rx_valid) |-> !m_res_reg.busy_res, "frame flagged while still busy")
    `SMSE_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> (!m_valid_reg && !skid_valid_reg), "buffer not empty after reset")

endmodule
